// ===== rtl/core/segment_intersection_graph_defines.svh =====
// Assertion macros used by the checker file of the segment intersection block.
`ifndef SEGMENT_INTERSECTION_GRAPH_DEFINES_SVH
`define SEGMENT_INTERSECTION_GRAPH_DEFINES_SVH

// Check that holds in the same cycle as its trigger.
`define SIG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that holds in the cycle after its trigger.
`define SIG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sig_pkg.sv =====
// Shared types and constants of the segment intersection block.
`timescale 1ns / 1ps

package sig_pkg;

	// Port widths fixed by the interface
	localparam int COORD_PORT_W = 30;
	localparam int IDX_W        = 6;
	localparam int HIT_W        = 6;

	// Defaults of the top level parameters
	localparam int DEF_MAX_SEGMENTS = 64;
	localparam int DEF_COORD_BITS   = 30;

	// Reports stop here so the summary still fits in the result budget
	localparam logic [HIT_W-1:0] REPORT_LIMIT = 6'd63;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_SUM  = 3'b100
	} sig_state_t;

	// Candidate tag that travels down the compare pipeline
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
	} sig_tag_t;

	// Result of the compare pipeline back to the sequencer
	typedef struct packed {
		logic             valid;
		logic             busy;
		logic             hit;
		logic [IDX_W-1:0] idx;
	} sig_res_t;

endpackage

// ===== rtl/core/sig_store.sv =====
// Segment store: one synchronous memory, one write and one registered read port.
`timescale 1ns / 1ps

module sig_store #(
	parameter int DEPTH = sig_pkg::DEF_MAX_SEGMENTS,
	parameter int WIDTH = 4 * sig_pkg::DEF_COORD_BITS,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data held while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/sig_cross.sv =====
// Proper intersection pipeline: differences, products, orientation signs.
`timescale 1ns / 1ps

module sig_cross #(
	parameter int COORD_BITS = sig_pkg::DEF_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  sig_pkg::sig_tag_t            tag_s1,
	input  logic signed [COORD_BITS-1:0] px0,
	input  logic signed [COORD_BITS-1:0] py0,
	input  logic signed [COORD_BITS-1:0] px1,
	input  logic signed [COORD_BITS-1:0] py1,
	input  logic [4*COORD_BITS-1:0]      q_s1,
	output sig_pkg::sig_res_t            res
);

	localparam int C = COORD_BITS;
	localparam int D = C + 1;
	localparam int P = 2 * D;

	logic signed [C-1:0] qx0, qy0, qx1, qy1;

	sig_pkg::sig_tag_t tag_s2, tag_s3, tag_s4;

	logic signed [D-1:0] dpx_s2, dpy_s2, dqx_s2, dqy_s2;
	logic signed [D-1:0] ax_s2, ay_s2, bx_s2, by_s2;
	logic signed [D-1:0] cx_s2, cy_s2, ex_s2, ey_s2;

	logic signed [P-1:0] m1_s3, m2_s3, m3_s3, m4_s3;
	logic signed [P-1:0] m5_s3, m6_s3, m7_s3, m8_s3;

	logic signed [P:0] o1, o2, o3, o4;
	logic              pos1, pos2, pos3, pos4;
	logic              neg1, neg2, neg3, neg4;
	logic              hit_s4;

	// stored word is {x0, y0, x1, y1}
	assign qx0 = q_s1[4*C-1 -: C];
	assign qy0 = q_s1[3*C-1 -: C];
	assign qx1 = q_s1[2*C-1 -: C];
	assign qy1 = q_s1[C-1 -: C];

	// valid bits of the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else if (adv) begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// stage 2: coordinate differences
	always_ff @(posedge clk) begin
		if (adv) begin
			dpx_s2 <= D'(px1) - D'(px0);
			dpy_s2 <= D'(py1) - D'(py0);
			dqx_s2 <= D'(qx1) - D'(qx0);
			dqy_s2 <= D'(qy1) - D'(qy0);
			ax_s2  <= D'(qx0) - D'(px0);
			ay_s2  <= D'(qy0) - D'(py0);
			bx_s2  <= D'(qx1) - D'(px0);
			by_s2  <= D'(qy1) - D'(py0);
			cx_s2  <= D'(px0) - D'(qx0);
			cy_s2  <= D'(py0) - D'(qy0);
			ex_s2  <= D'(px1) - D'(qx0);
			ey_s2  <= D'(py1) - D'(qy0);
		end
	end

	// stage 3: the eight cross product terms
	always_ff @(posedge clk) begin
		if (adv) begin
			m1_s3 <= dpx_s2 * ay_s2;
			m2_s3 <= ax_s2 * dpy_s2;
			m3_s3 <= dpx_s2 * by_s2;
			m4_s3 <= bx_s2 * dpy_s2;
			m5_s3 <= dqx_s2 * cy_s2;
			m6_s3 <= cx_s2 * dqy_s2;
			m7_s3 <= dqx_s2 * ey_s2;
			m8_s3 <= ex_s2 * dqy_s2;
		end
	end

	// orientations about the new segment (o1, o2) and the stored one (o3, o4)
	always_comb begin
		o1   = (P+1)'(m1_s3) - (P+1)'(m2_s3);
		o2   = (P+1)'(m3_s3) - (P+1)'(m4_s3);
		o3   = (P+1)'(m5_s3) - (P+1)'(m6_s3);
		o4   = (P+1)'(m7_s3) - (P+1)'(m8_s3);
		neg1 = o1[P];
		neg2 = o2[P];
		neg3 = o3[P];
		neg4 = o4[P];
		pos1 = !o1[P] && (|o1);
		pos2 = !o2[P] && (|o2);
		pos3 = !o3[P] && (|o3);
		pos4 = !o4[P] && (|o4);
	end

	// stage 4: strictly opposite signs on both segments
	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s4 <= ((pos1 && neg2) || (neg1 && pos2)) &&
			          ((pos3 && neg4) || (neg3 && pos4));
		end
	end

	assign res.valid = tag_s4.valid;
	assign res.busy  = tag_s2.valid || tag_s3.valid || tag_s4.valid;
	assign res.hit   = hit_s4;
	assign res.idx   = tag_s4.idx;

endmodule

// ===== rtl/core/segment_intersection_graph.sv =====
// Top level: proper intersection test of each new segment against the stored set.
//
// Input channel (in_valid/in_ready) carries one segment word: two end points and
// start_new_set, which empties the set before the segment is handled. Output
// channel (out_valid/out_ready) returns one report word per stored segment that
// properly crosses the new one (ascending partner_index, at most 63), then one
// summary word with is_summary and last set, the hit count and the new index.
// Each stored segment is read into the read register (s1) and passes the compare
// stages s2 to s4 and the output register before its report appears. One stored
// segment is compared per cycle while the receiver does not stall, set by the single
// read port of the segment memory; a new word is taken once the summary has been
// loaded.
// Reset empties the set at once; no memory clearing pass is needed.
// A stalled receiver freezes the compare pipeline and the memory read; the
// output register holds its word until taken.
`timescale 1ns / 1ps

module segment_intersection_graph #(
	parameter int MAX_SEGMENTS = sig_pkg::DEF_MAX_SEGMENTS,
	parameter int COORD_BITS   = sig_pkg::DEF_COORD_BITS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic signed [sig_pkg::COORD_PORT_W-1:0]  start_x,
	input  logic signed [sig_pkg::COORD_PORT_W-1:0]  start_y,
	input  logic signed [sig_pkg::COORD_PORT_W-1:0]  end_x,
	input  logic signed [sig_pkg::COORD_PORT_W-1:0]  end_y,
	input  logic                                     start_new_set,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic                                     is_summary,
	output logic [sig_pkg::IDX_W-1:0]                partner_index,
	output logic [sig_pkg::IDX_W-1:0]                new_index,
	output logic [sig_pkg::HIT_W-1:0]                hit_count,
	output logic                                     set_full,
	output logic                                     last
);

	localparam int C  = COORD_BITS;
	localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int IW = sig_pkg::IDX_W;
	localparam int HW = sig_pkg::HIT_W;

	sig_pkg::sig_state_t state_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rd_idx_q;
	logic          full_q;
	logic [IW-1:0] idx_q;
	logic [HW-1:0] hits_q;

	logic signed [C-1:0] px0_q, py0_q, px1_q, py1_q;

	sig_pkg::sig_tag_t tag_s1;
	sig_pkg::sig_res_t res;
	logic [4*C-1:0]    rdata_s1;

	logic          out_valid_q;
	logic          is_summary_q;
	logic [IW-1:0] partner_q;
	logic [IW-1:0] new_index_q;
	logic [HW-1:0] hit_count_q;
	logic          set_full_q;
	logic          last_q;

	logic          accept;
	logic          adv;
	logic          issue;
	logic          drained;
	logic          emit_rep;
	logic          emit_sum;
	logic [CW-1:0] cnt_nx;
	logic          full_nx;

	// handshake and pipeline advance
	assign in_ready = (state_q == sig_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign adv      = !out_valid_q || out_ready;
	assign issue    = (state_q == sig_pkg::ST_SCAN) && (rd_idx_q < cnt_q);
	assign drained  = !tag_s1.valid && !res.busy;
	assign emit_rep = res.valid && res.hit && (hits_q != sig_pkg::REPORT_LIMIT);
	assign emit_sum = (state_q == sig_pkg::ST_SUM);

	// set size seen by the new word
	assign cnt_nx  = start_new_set ? '0 : count_q;
	assign full_nx = (cnt_nx == CW'(MAX_SEGMENTS));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sig_pkg::ST_IDLE;
			count_q     <= '0;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			full_q      <= 1'b0;
			idx_q       <= '0;
			hits_q      <= '0;
			tag_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				sig_pkg::ST_IDLE: begin
					if (accept) begin
						cnt_q    <= cnt_nx;
						full_q   <= full_nx;
						idx_q    <= full_nx ? '0 : IW'(cnt_nx[AW-1:0]);
						rd_idx_q <= '0;
						hits_q   <= '0;
						state_q  <= sig_pkg::ST_SCAN;
					end
				end
				sig_pkg::ST_SCAN: begin
					if (adv && issue) begin
						rd_idx_q <= CW'(rd_idx_q + 1'b1);
					end
					if (!issue && drained) begin
						state_q <= sig_pkg::ST_SUM;
					end
				end
				sig_pkg::ST_SUM: begin
					if (adv) begin
						if (!full_q) begin
							count_q <= CW'(cnt_q + 1'b1);
						end
						state_q <= sig_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= sig_pkg::ST_IDLE;
				end
			endcase

			if (adv) begin
				tag_s1.valid <= issue;
				tag_s1.idx   <= IW'(rd_idx_q[AW-1:0]);
				out_valid_q  <= emit_rep || emit_sum;
				if (emit_rep) begin
					hits_q <= HW'(hits_q + 1'b1);
				end
			end
		end
	end

	// new segment, cut to COORD_BITS
	always_ff @(posedge clk) begin
		if (accept) begin
			px0_q <= start_x[C-1:0];
			py0_q <= start_y[C-1:0];
			px1_q <= end_x[C-1:0];
			py1_q <= end_y[C-1:0];
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (adv) begin
			if (emit_sum) begin
				is_summary_q <= 1'b1;
				partner_q    <= '0;
				new_index_q  <= idx_q;
				hit_count_q  <= hits_q;
				set_full_q   <= full_q;
				last_q       <= 1'b1;
			end else if (emit_rep) begin
				is_summary_q <= 1'b0;
				partner_q    <= res.idx;
				new_index_q  <= idx_q;
				hit_count_q  <= '0;
				set_full_q   <= full_q;
				last_q       <= 1'b0;
			end
		end
	end

	sig_store #(
		.DEPTH (MAX_SEGMENTS),
		.WIDTH (4 * C)
	) u_store (
		.clk     (clk),
		.wr_en   (emit_sum && adv && !full_q),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data ({px0_q, py0_q, px1_q, py1_q}),
		.rd_en   (adv),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (rdata_s1)
	);

	sig_cross #(
		.COORD_BITS (C)
	) u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.tag_s1 (tag_s1),
		.px0    (px0_q),
		.py0    (py0_q),
		.px1    (px1_q),
		.py1    (py1_q),
		.q_s1   (rdata_s1),
		.res    (res)
	);

	assign out_valid     = out_valid_q;
	assign is_summary    = is_summary_q;
	assign partner_index = partner_q;
	assign new_index     = new_index_q;
	assign hit_count     = hit_count_q;
	assign set_full      = set_full_q;
	assign last          = last_q;

endmodule

// ===== rtl/core/sig_checker.sv =====
// Port-level checks of the segment intersection block and their bind.
`timescale 1ns / 1ps
`include "segment_intersection_graph_defines.svh"

module sig_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_ready,
	input logic signed [sig_pkg::COORD_PORT_W-1:0] start_x,
	input logic signed [sig_pkg::COORD_PORT_W-1:0] start_y,
	input logic signed [sig_pkg::COORD_PORT_W-1:0] end_x,
	input logic signed [sig_pkg::COORD_PORT_W-1:0] end_y,
	input logic                                    start_new_set,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic                                    is_summary,
	input logic [sig_pkg::IDX_W-1:0]               partner_index,
	input logic [sig_pkg::IDX_W-1:0]               new_index,
	input logic [sig_pkg::HIT_W-1:0]               hit_count,
	input logic                                    set_full,
	input logic                                    last
);

	// only the summary closes a word group
	`SIG_ASSERT_SAME(a_last_summary, out_valid, last == is_summary, "last differs from is_summary")

	// a segment that was not stored carries index zero
	`SIG_ASSERT_SAME(a_full_index, out_valid && set_full, new_index == '0, "full set with nonzero index")

	// a taken segment word drops the input ready right after the take
	`SIG_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "input ready right after a take")

	// a stalled result word holds
	`SIG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(partner_index) && $stable(new_index) && $stable(hit_count) && $stable(last), "stalled word changed")

endmodule

bind segment_intersection_graph sig_checker u_sig_checker (.*);
